@@ design/sdd_pkg.sv @@
// sdd_pkg: shared types and constants for the serial date decoder
// used by sdd_ctrl, sdd_dp and serial_date_decode; no dependencies
`default_nettype none

package sdd_pkg;

	// stride phases of the shared subtract loop
	typedef enum logic [2:0] {
		PH_400,
		PH_100,
		PH_4,
		PH_1,
		PH_MON
	} sdd_phase_t;

	// controller to datapath
	typedef struct packed {
		logic       load;
		logic       mod_step;
		logic       step;
		sdd_phase_t phase;
		logic       mark_doy;
		logic       finish;
	} sdd_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic range_ok;
		logic can_step;
	} sdd_stat_t;

	localparam int SerialW = 23;
	localparam int RemW    = 22;
	localparam int YearW   = 14;

	// 0100-01-01 and 9999-12-31 as serials
	localparam logic signed [SerialW:0] SerialMin = -24'sd657434;
	localparam logic signed [SerialW:0] SerialMax = 24'sd2958465;
	// moves serial to days since 0001-01-01
	localparam logic signed [SerialW:0] OffsetDays = 24'sd693593;
	// -1 plus a multiple of 7 that keeps the weekday count positive
	localparam logic [SerialW:0] WeekBias = 24'd4199999;

	localparam logic [RemW-1:0] Days400 = 22'd146097;
	localparam logic [RemW-1:0] Days100 = 22'd36524;
	localparam logic [RemW-1:0] Days4   = 22'd1461;
	localparam logic [RemW-1:0] Days1   = 22'd365;

	localparam logic [YearW-1:0] Inc400 = 14'd400;
	localparam logic [YearW-1:0] Inc100 = 14'd100;
	localparam logic [YearW-1:0] Inc4   = 14'd4;
	localparam logic [YearW-1:0] Inc1   = 14'd1;

	function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
		logic [4:0] len;
		begin
			unique case (month)
				4'd2:                         len = leap ? 5'd29 : 5'd28;
				4'd4, 4'd6, 4'd9, 4'd11:      len = 5'd30;
				default:                      len = 5'd31;
			endcase
			return len;
		end
	endfunction

endpackage

`default_nettype wire

@@ design/sdd_ctrl.sv @@
// sdd_ctrl: sequencer for the serial date decoder
// depends on sdd_pkg; drives sdd_dp through sdd_cmd_t
`default_nettype none

module sdd_ctrl (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              start,
	output logic             busy,
	output logic             done,
	input  sdd_pkg::sdd_stat_t stat,
	output sdd_pkg::sdd_cmd_t  cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MOD7,
		ST_Y400,
		ST_Y100,
		ST_Y4,
		ST_Y1,
		ST_MON,
		ST_FIN
	} state_t;

	state_t     state_q;
	logic       done_q;

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;

	always_comb begin
		cmd          = '0;
		cmd.phase    = sdd_pkg::PH_400;
		unique case (state_q)
			ST_IDLE: cmd.load = start;
			ST_MOD7: cmd.mod_step = 1'b1;
			ST_Y400: begin
				cmd.phase = sdd_pkg::PH_400;
				cmd.step  = stat.can_step;
			end
			ST_Y100: begin
				cmd.phase = sdd_pkg::PH_100;
				cmd.step  = stat.can_step;
			end
			ST_Y4: begin
				cmd.phase = sdd_pkg::PH_4;
				cmd.step  = stat.can_step;
			end
			ST_Y1: begin
				cmd.phase    = sdd_pkg::PH_1;
				cmd.step     = stat.can_step;
				cmd.mark_doy = !stat.can_step;
			end
			ST_MON: begin
				cmd.phase = sdd_pkg::PH_MON;
				cmd.step  = stat.can_step;
			end
			ST_FIN: cmd.finish = 1'b1;
			default: cmd.load = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_MOD7;
					end
				end
				// weekday residue folds while in ST_MOD7
				ST_MOD7: state_q <= stat.range_ok ? ST_Y400 : ST_FIN;
				ST_Y400: if (!stat.can_step) state_q <= ST_Y100;
				ST_Y100: if (!stat.can_step) state_q <= ST_Y4;
				ST_Y4:   if (!stat.can_step) state_q <= ST_Y1;
				ST_Y1:   if (!stat.can_step) state_q <= ST_MON;
				ST_MON:  if (!stat.can_step) state_q <= ST_FIN;
				ST_FIN: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

@@ design/sdd_dp.sv @@
// sdd_dp: datapath of the serial date decoder, one shared stride subtractor
// plus a modulo-7 digit fold; depends on sdd_pkg
`default_nettype none

module sdd_dp (
	input  wire                              clk,
	input  wire signed [sdd_pkg::SerialW-1:0] serial_day,
	input  wire  [2:0]                       week_start_day,
	input  sdd_pkg::sdd_cmd_t                cmd,
	output sdd_pkg::sdd_stat_t               stat,
	output logic [sdd_pkg::YearW-1:0]        cal_year,
	output logic [3:0]                       cal_month,
	output logic [4:0]                       cal_day,
	output logic [8:0]                       day_of_year,
	output logic [2:0]                       weekday,
	output logic                             out_of_range
);

	logic signed [sdd_pkg::SerialW:0] s_ext;
	logic signed [sdd_pkg::SerialW:0] days_abs;
	logic [sdd_pkg::SerialW:0]        wk_val;
	logic                             in_range;

	logic [sdd_pkg::SerialW:0]        wk_q;
	logic [2:0]                       m7_q;
	logic [sdd_pkg::RemW-1:0]         rem_q;
	logic [sdd_pkg::YearW-1:0]        year_q;
	logic [1:0]                       c100_q;
	logic [4:0]                       c4_q;
	logic [1:0]                       c1_q;
	logic [3:0]                       month_q;
	logic [8:0]                       doy_q;
	logic                             range_ok_q;

	logic [sdd_pkg::RemW-1:0]         stride;
	logic [sdd_pkg::YearW-1:0]        yinc;
	logic [sdd_pkg::RemW:0]           diff;
	logic                             limit_ok;
	logic                             leap;
	logic [5:0]                       oct_sum;
	logic [3:0]                       oct_fold;
	logic [2:0]                       m7_sum;
	logic [2:0]                       m7_next;
	logic [2:0]                       first_day;
	logic [3:0]                       dow_tmp;
	logic [3:0]                       dow;

	assign s_ext    = {serial_day[sdd_pkg::SerialW-1], serial_day};
	assign days_abs = s_ext + sdd_pkg::OffsetDays;
	assign wk_val   = s_ext + sdd_pkg::WeekBias;
	assign in_range = (s_ext >= sdd_pkg::SerialMin) && (s_ext <= sdd_pkg::SerialMax);

	// last year of a four-year group; century years only every fourth century
	assign leap = (c1_q == 2'd3) && ((c4_q != 5'd24) || (c100_q == 2'd3));

	always_comb begin
		stride   = sdd_pkg::Days400;
		yinc     = sdd_pkg::Inc400;
		limit_ok = 1'b1;
		unique case (cmd.phase)
			sdd_pkg::PH_400: begin
				stride = sdd_pkg::Days400;
				yinc   = sdd_pkg::Inc400;
			end
			sdd_pkg::PH_100: begin
				stride   = sdd_pkg::Days100;
				yinc     = sdd_pkg::Inc100;
				limit_ok = (c100_q != 2'd3);
			end
			sdd_pkg::PH_4: begin
				stride = sdd_pkg::Days4;
				yinc   = sdd_pkg::Inc4;
			end
			sdd_pkg::PH_1: begin
				stride   = sdd_pkg::Days1;
				yinc     = sdd_pkg::Inc1;
				limit_ok = (c1_q != 2'd3);
			end
			sdd_pkg::PH_MON: begin
				stride = sdd_pkg::RemW'(sdd_pkg::month_len(month_q, leap));
				yinc   = '0;
			end
			default: limit_ok = 1'b0;
		endcase
	end

	assign diff          = {1'b0, rem_q} - {1'b0, stride};
	assign stat.can_step = !diff[sdd_pkg::RemW] && limit_ok;
	assign stat.range_ok = range_ok_q;

	// 8 is 1 mod 7, so the octal digits sum to the same residue
	always_comb begin
		oct_sum = '0;
		for (int i = 0; i < 8; i++) begin
			oct_sum = oct_sum + 6'(wk_q[3*i +: 3]);
		end
	end

	assign oct_fold = {1'b0, oct_sum[5:3]} + {1'b0, oct_sum[2:0]};
	assign m7_sum   = {2'b00, oct_fold[3]} + oct_fold[2:0];
	assign m7_next  = (m7_sum == 3'd7) ? 3'd0 : m7_sum;

	// m7_q is 0 for sunday; shift by the configured first day and wrap
	assign first_day = (week_start_day == 3'd0) ? 3'd1 : week_start_day;
	assign dow_tmp   = {1'b0, m7_q} + 4'd9 - {1'b0, first_day};
	assign dow       = (dow_tmp > 4'd7) ? (dow_tmp - 4'd7) : dow_tmp;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			wk_q       <= wk_val;
			m7_q       <= '0;
			rem_q      <= days_abs[sdd_pkg::RemW-1:0];
			range_ok_q <= in_range;
			year_q     <= sdd_pkg::YearW'(1);
			c100_q     <= '0;
			c4_q       <= '0;
			c1_q       <= '0;
			month_q    <= 4'd1;
		end
		if (cmd.mod_step) begin
			m7_q <= m7_next;
		end
		if (cmd.step) begin
			rem_q  <= diff[sdd_pkg::RemW-1:0];
			year_q <= year_q + yinc;
			unique case (cmd.phase)
				sdd_pkg::PH_100: c100_q <= c100_q + 2'd1;
				sdd_pkg::PH_4:   c4_q   <= c4_q + 5'd1;
				sdd_pkg::PH_1:   c1_q   <= c1_q + 2'd1;
				sdd_pkg::PH_MON: month_q <= month_q + 4'd1;
				default:         c100_q <= c100_q;
			endcase
		end
		if (cmd.mark_doy) begin
			doy_q <= rem_q[8:0];
		end
		if (cmd.finish) begin
			weekday      <= dow[2:0];
			out_of_range <= !range_ok_q;
			if (range_ok_q) begin
				cal_year    <= year_q;
				cal_month   <= month_q;
				cal_day     <= rem_q[4:0] + 5'd1;
				day_of_year <= doy_q + 9'd1;
			end else begin
				cal_year    <= '0;
				cal_month   <= '0;
				cal_day     <= '0;
				day_of_year <= '0;
			end
		end
	end

endmodule

`default_nettype wire

@@ design/serial_date_decode.sv @@
// serial_date_decode: serial day number to Gregorian date, top level
// holds the register port; depends on sdd_pkg, sdd_ctrl, sdd_dp
// sequence: after the start beat the modulo-7 fold runs, then ST_FIN for an out-of-range serial;
// otherwise one stride subtract per cycle through the 400-year, 100-year, 4-year, year and
// month loops, each ending on a failed compare, before ST_FIN raises done
// one item at a time, busy meanwhile; the next start is taken while done is high
// done is high for one cycle with the result; the receiver cannot stall
// reset clears the sequencer and sets week_start_day to 1
`default_nettype none

module serial_date_decode (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              psel,
	input  wire                              penable,
	input  wire                              pwrite,
	input  wire  [2:0]                       paddr,
	input  wire  [31:0]                      pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready,
	input  wire                              start,
	output logic                             busy,
	input  wire signed [sdd_pkg::SerialW-1:0] serial_day,
	output logic                             done,
	output logic [sdd_pkg::YearW-1:0]        cal_year,
	output logic [3:0]                       cal_month,
	output logic [4:0]                       cal_day,
	output logic [8:0]                       day_of_year,
	output logic [2:0]                       weekday,
	output logic                             out_of_range
);

	logic [2:0]         week_start_q;
	logic               wr_en;
	sdd_pkg::sdd_cmd_t  cmd;
	sdd_pkg::sdd_stat_t stat;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			week_start_q <= 3'd1;
		end else if (wr_en && !paddr[2]) begin
			week_start_q <= pwdata[2:0];
		end
	end

	assign prdata = paddr[2] ? 32'd0 : {29'd0, week_start_q};

	sdd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.stat   (stat),
		.cmd    (cmd)
	);

	sdd_dp u_dp (
		.clk            (clk),
		.serial_day     (serial_day),
		.week_start_day (week_start_q),
		.cmd            (cmd),
		.stat           (stat),
		.cal_year       (cal_year),
		.cal_month      (cal_month),
		.cal_day        (cal_day),
		.day_of_year    (day_of_year),
		.weekday        (weekday),
		.out_of_range   (out_of_range)
	);

endmodule

`default_nettype wire
